>>> rtl/jdz_pkg.sv
// Shared types and constants for the joystick dead zone unit.
// No dependencies; used by jdz_div and joystick_dead_zone_unit.
package jdz_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 14;
  localparam int OUT_W       = FRAC_BITS + 2;
  localparam int Q_W         = FRAC_BITS + 1;   // quotient bits kept before clamp
  localparam int NUM_W       = SAMPLE_BITS + FRAC_BITS;  // magnitude << FRAC_BITS
  localparam int DEN_W       = SAMPLE_BITS;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int ADDR_W      = 4;
  localparam int DZ_W        = SAMPLE_BITS - 1;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_AXIS = 2'd1;
  localparam logic [1:0] MODE_CIRC = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_DZ   = 2'd2;

  localparam logic [1:0]             RST_MODE = MODE_AXIS;
  localparam logic [SAMPLE_BITS-1:0] RST_MAX  = 16'd32767;
  localparam logic [DZ_W-1:0]        RST_DZ   = 15'd7849;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1 << FRAC_BITS);

  // everything an item carries down the pipe
  typedef struct packed {
    logic                   neg_x;
    logic                   neg_y;
    logic [SAMPLE_BITS-1:0] ax;
    logic [SAMPLE_BITS-1:0] ay;
    logic                   circ;
    logic                   span_ok;
    logic [DZ_W-1:0]        dz;
    logic [DEN_W-1:0]       span;
    logic [ROOT_W-1:0]      len;
    logic                   zx;
    logic                   zy;
    logic [Q_W-1:0]         w;
    logic [OUT_W-1:0]       rx;
    logic [OUT_W-1:0]       ry;
  } item_t;

endpackage

>>> rtl/jdz_div.sv
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
// Depends on jdz_pkg.
module jdz_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [jdz_pkg::NUM_W-1:0]  in_num_a,
  input  logic [jdz_pkg::NUM_W-1:0]  in_num_b,
  input  logic [jdz_pkg::DEN_W-1:0]  in_den,
  input  jdz_pkg::item_t             in_tag,
  output logic                       out_vld,
  output logic [jdz_pkg::Q_W-1:0]    out_q_a,
  output logic [jdz_pkg::Q_W-1:0]    out_q_b,
  output logic                       out_ovf_a,
  output logic                       out_ovf_b,
  output jdz_pkg::item_t             out_tag
);

  localparam int NS = jdz_pkg::Q_W;
  localparam int DW = jdz_pkg::DEN_W;

  function automatic logic [DW:0] div_step(logic [DW-1:0] rem, logic nb, logic [DW-1:0] den);
    logic [DW:0] t;
    logic        ge;
    t  = {rem, nb};
    ge = t >= {1'b0, den};
    return {ge, ge ? DW'(t - {1'b0, den}) : t[DW-1:0]};
  endfunction

  logic                vld_r   [NS];
  logic [DW-1:0]       rem_a_r [NS];
  logic [DW-1:0]       rem_b_r [NS];
  logic [NS-1:0]       low_a_r [NS];
  logic [NS-1:0]       low_b_r [NS];
  logic [NS-1:0]       q_a_r   [NS];
  logic [NS-1:0]       q_b_r   [NS];
  logic                ovf_a_r [NS];
  logic                ovf_b_r [NS];
  logic [DW-1:0]       den_r   [NS];
  jdz_pkg::item_t      tag_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic           vld_src, ovf_a_src, ovf_b_src;
    logic [DW-1:0]  rem_a_src, rem_b_src, den_src;
    logic [NS-1:0]  low_a_src, low_b_src, q_a_src, q_b_src;
    jdz_pkg::item_t tag_src;
    logic [DW:0]    st_a, st_b;

    if (k == 0) begin : g_first
      always_comb begin
        vld_src   = in_vld;
        // top numerator bits go straight into the remainder; overflow if that already
        // reaches the divisor (quotient would not fit)
        rem_a_src = DW'(in_num_a[jdz_pkg::NUM_W-1:NS]);
        rem_b_src = DW'(in_num_b[jdz_pkg::NUM_W-1:NS]);
        ovf_a_src = DW'(in_num_a[jdz_pkg::NUM_W-1:NS]) >= in_den;
        ovf_b_src = DW'(in_num_b[jdz_pkg::NUM_W-1:NS]) >= in_den;
        low_a_src = in_num_a[NS-1:0];
        low_b_src = in_num_b[NS-1:0];
        q_a_src   = '0;
        q_b_src   = '0;
        den_src   = in_den;
        tag_src   = in_tag;
      end
    end else begin : g_next
      always_comb begin
        vld_src   = vld_r[k-1];
        rem_a_src = rem_a_r[k-1];
        rem_b_src = rem_b_r[k-1];
        ovf_a_src = ovf_a_r[k-1];
        ovf_b_src = ovf_b_r[k-1];
        low_a_src = low_a_r[k-1];
        low_b_src = low_b_r[k-1];
        q_a_src   = q_a_r[k-1];
        q_b_src   = q_b_r[k-1];
        den_src   = den_r[k-1];
        tag_src   = tag_r[k-1];
      end
    end

    assign st_a = div_step(rem_a_src, low_a_src[NS-1], den_src);
    assign st_b = div_step(rem_b_src, low_b_src[NS-1], den_src);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_a_r[k] <= st_a[DW-1:0];
      rem_b_r[k] <= st_b[DW-1:0];
      low_a_r[k] <= low_a_src << 1;
      low_b_r[k] <= low_b_src << 1;
      q_a_r[k]   <= {q_a_src[NS-2:0], st_a[DW]};
      q_b_r[k]   <= {q_b_src[NS-2:0], st_b[DW]};
      ovf_a_r[k] <= ovf_a_src;
      ovf_b_r[k] <= ovf_b_src;
      den_r[k]   <= den_src;
      tag_r[k]   <= tag_src;
    end
  end

  assign out_vld   = vld_r[NS-1];
  assign out_q_a   = q_a_r[NS-1];
  assign out_q_b   = q_b_r[NS-1];
  assign out_ovf_a = ovf_a_r[NS-1];
  assign out_ovf_b = ovf_b_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

>>> rtl/joystick_dead_zone_unit.sv
// Channel   Ports                                  Handshake
// input     start, busy, in_raw_x, in_raw_y        beat when start & !busy
// result    out_valid, out_x, out_y                one-cycle strobe, no backpressure
// config    psel, penable, pwrite, paddr, pwdata,  APB write on access phase,
//           prdata, pready                         pready tied high
//
// Fully pipelined: one beat per cycle, busy is never raised. Each beat passes through
// registered stages in order (input, square, sum, 16 root stages, dead zone,
// 15-stage divide by span, clamp, multiply, 15-stage divide by length, output).
// Synchronous active-low reset clears the valid chain and loads register defaults.
// Depends on jdz_pkg and jdz_div.
module joystick_dead_zone_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [jdz_pkg::SAMPLE_BITS-1:0] in_raw_x,
  input  logic signed [jdz_pkg::SAMPLE_BITS-1:0] in_raw_y,
  output logic                                out_valid,
  output logic signed [jdz_pkg::OUT_W-1:0]    out_x,
  output logic signed [jdz_pkg::OUT_W-1:0]    out_y,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [jdz_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int SB = jdz_pkg::SAMPLE_BITS;
  localparam int NR = jdz_pkg::ROOT_W;
  localparam int RW = jdz_pkg::REM_W;
  localparam int QW = jdz_pkg::Q_W;
  localparam int OW = jdz_pkg::OUT_W;

  // ---------------- configuration ----------------
  logic [1:0]             mode_r;
  logic [SB-1:0]          max_r;
  logic [jdz_pkg::DZ_W-1:0] dz_r;
  logic                   wr_en;
  logic [1:0]             reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jdz_pkg::RST_MODE;
      max_r  <= jdz_pkg::RST_MAX;
      dz_r   <= jdz_pkg::RST_DZ;
    end else if (wr_en) begin
      case (reg_idx)
        jdz_pkg::REG_MODE: mode_r <= pwdata[1:0];
        jdz_pkg::REG_MAX:  max_r  <= pwdata[SB-1:0];
        jdz_pkg::REG_DZ:   dz_r   <= pwdata[jdz_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      jdz_pkg::REG_MODE: prdata = 32'(mode_r);
      jdz_pkg::REG_MAX:  prdata = 32'(max_r);
      jdz_pkg::REG_DZ:   prdata = 32'(dz_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------- stage 1: capture ----------------
  jdz_pkg::item_t         s1_nxt, s1_r;
  logic                   s1_vld_r;
  logic [jdz_pkg::DZ_W-1:0] dz_eff;
  logic [SB:0]            span_w;

  always_comb begin
    dz_eff = (mode_r == jdz_pkg::MODE_AXIS || mode_r == jdz_pkg::MODE_CIRC) ? dz_r : '0;
    span_w = {1'b0, max_r} - (SB+1)'(dz_eff);
    s1_nxt         = '0;
    s1_nxt.neg_x   = in_raw_x[SB-1];
    s1_nxt.neg_y   = in_raw_y[SB-1];
    s1_nxt.ax      = in_raw_x[SB-1] ? SB'(-in_raw_x) : SB'(in_raw_x);
    s1_nxt.ay      = in_raw_y[SB-1] ? SB'(-in_raw_y) : SB'(in_raw_y);
    s1_nxt.circ    = mode_r == jdz_pkg::MODE_CIRC;
    s1_nxt.span_ok = !span_w[SB] && (span_w != '0);
    s1_nxt.dz      = dz_eff;
    s1_nxt.span    = span_w[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // ---------------- stages 2-3: sum of squares ----------------
  logic                   s2_vld_r, s3_vld_r;
  jdz_pkg::item_t         s2_r, s3_r;
  logic [2*SB-1:0]        xx_r, yy_r;
  logic [jdz_pkg::SQ_W-1:0] sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    xx_r <= s1_r.ax * s1_r.ax;
    yy_r <= s1_r.ay * s1_r.ay;
    s2_r <= s1_r;
    sq_r <= jdz_pkg::SQ_W'(xx_r + yy_r);
    s3_r <= s2_r;
  end

  // ---------------- integer square root, one root bit per stage ----------------
  logic                     rt_vld_r  [NR];
  logic [RW-1:0]            rt_rem_r  [NR];
  logic [NR-1:0]            rt_root_r [NR];
  logic [jdz_pkg::SQ_W-1:0] rt_rad_r  [NR];
  jdz_pkg::item_t           rt_item_r [NR];

  for (genvar j = 0; j < NR; j++) begin : g_root
    logic                     vld_src;
    logic [RW-1:0]            rem_src, rem_nxt;
    logic [NR-1:0]            root_src, root_nxt;
    logic [jdz_pkg::SQ_W-1:0] rad_src;
    jdz_pkg::item_t           item_src;
    logic [RW+1:0]            trial, cand;

    if (j == 0) begin : g_first
      always_comb begin
        vld_src  = s3_vld_r;
        rem_src  = '0;
        root_src = '0;
        rad_src  = sq_r;
        item_src = s3_r;
      end
    end else begin : g_next
      always_comb begin
        vld_src  = rt_vld_r[j-1];
        rem_src  = rt_rem_r[j-1];
        root_src = rt_root_r[j-1];
        rad_src  = rt_rad_r[j-1];
        item_src = rt_item_r[j-1];
      end
    end

    always_comb begin
      trial = {rem_src, rad_src[jdz_pkg::SQ_W-1 -: 2]};
      cand  = (RW+2)'({root_src, 2'b01});
      if (trial >= cand) begin
        rem_nxt  = RW'(trial - cand);
        root_nxt = {root_src[NR-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[RW-1:0];
        root_nxt = {root_src[NR-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_vld_r[j] <= 1'b0;
      end else begin
        rt_vld_r[j] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      rt_rem_r[j]  <= rem_nxt;
      rt_root_r[j] <= root_nxt;
      rt_rad_r[j]  <= rad_src << 2;
      rt_item_r[j] <= item_src;
    end
  end

  // ---------------- dead zone subtract ----------------
  logic                   dz_vld_r;
  jdz_pkg::item_t         dz_item_nxt, dz_item_r;
  logic [SB-1:0]          ax_sel, vx_nxt, vy_nxt, vx_r, vy_r;

  always_comb begin
    dz_item_nxt     = rt_item_r[NR-1];
    dz_item_nxt.len = rt_root_r[NR-1];
    ax_sel = dz_item_nxt.circ ? dz_item_nxt.len : dz_item_nxt.ax;
    dz_item_nxt.zx = !(ax_sel > SB'(dz_item_nxt.dz));
    dz_item_nxt.zy = !(dz_item_nxt.ay > SB'(dz_item_nxt.dz));
    vx_nxt = ax_sel - SB'(dz_item_nxt.dz);
    vy_nxt = dz_item_nxt.ay - SB'(dz_item_nxt.dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_vld_r <= 1'b0;
    end else begin
      dz_vld_r <= rt_vld_r[NR-1];
    end
  end

  always_ff @(posedge clk) begin
    dz_item_r <= dz_item_nxt;
    vx_r      <= vx_nxt;
    vy_r      <= vy_nxt;
  end

  // ---------------- divide by span ----------------
  logic           d1_vld, d1_ovf_a, d1_ovf_b;
  logic [QW-1:0]  d1_q_a, d1_q_b;
  jdz_pkg::item_t d1_tag;

  jdz_div u_div_span (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (dz_vld_r),
    .in_num_a  (jdz_pkg::NUM_W'({vx_r, jdz_pkg::FRAC_BITS'(0)})),
    .in_num_b  (jdz_pkg::NUM_W'({vy_r, jdz_pkg::FRAC_BITS'(0)})),
    .in_den    (dz_item_r.span),
    .in_tag    (dz_item_r),
    .out_vld   (d1_vld),
    .out_q_a   (d1_q_a),
    .out_q_b   (d1_q_b),
    .out_ovf_a (d1_ovf_a),
    .out_ovf_b (d1_ovf_b),
    .out_tag   (d1_tag)
  );

  // ---------------- clamp, sign ----------------
  logic           cl_vld_r;
  jdz_pkg::item_t cl_item_nxt, cl_item_r;
  logic [QW-1:0]  mag_x, mag_y;

  always_comb begin
    cl_item_nxt = d1_tag;
    mag_x = (d1_ovf_a || d1_q_a > jdz_pkg::ONE_Q) ? jdz_pkg::ONE_Q : d1_q_a;
    mag_y = (d1_ovf_b || d1_q_b > jdz_pkg::ONE_Q) ? jdz_pkg::ONE_Q : d1_q_b;
    if (d1_tag.zx || !d1_tag.span_ok) mag_x = '0;
    if (d1_tag.zy || !d1_tag.span_ok) mag_y = '0;
    cl_item_nxt.w  = mag_x;
    cl_item_nxt.rx = d1_tag.neg_x ? OW'(-{1'b0, mag_x}) : OW'({1'b0, mag_x});
    cl_item_nxt.ry = d1_tag.neg_y ? OW'(-{1'b0, mag_y}) : OW'({1'b0, mag_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_vld_r <= 1'b0;
    end else begin
      cl_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    cl_item_r <= cl_item_nxt;
  end

  // ---------------- scale axes by the conditioned length ----------------
  logic                      mu_vld_r;
  jdz_pkg::item_t            mu_item_r;
  logic [jdz_pkg::NUM_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vld_r <= 1'b0;
    end else begin
      mu_vld_r <= cl_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= jdz_pkg::NUM_W'(cl_item_r.ax * cl_item_r.w);
    py_r      <= jdz_pkg::NUM_W'(cl_item_r.ay * cl_item_r.w);
    mu_item_r <= cl_item_r;
  end

  logic           d2_vld, d2_ovf_a, d2_ovf_b;
  logic [QW-1:0]  d2_q_a, d2_q_b;
  jdz_pkg::item_t d2_tag;

  jdz_div u_div_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (mu_vld_r),
    .in_num_a  (px_r),
    .in_num_b  (py_r),
    .in_den    (mu_item_r.len),
    .in_tag    (mu_item_r),
    .out_vld   (d2_vld),
    .out_q_a   (d2_q_a),
    .out_q_b   (d2_q_b),
    .out_ovf_a (d2_ovf_a),
    .out_ovf_b (d2_ovf_b),
    .out_tag   (d2_tag)
  );

  // ---------------- output register ----------------
  logic          circ_ok;
  logic [OW-1:0] ox_nxt, oy_nxt;
  logic [OW-1:0] ox_r, oy_r;
  logic          ov_r;

  always_comb begin
    // quotient never exceeds w here since |axis| <= length
    circ_ok = (d2_tag.w != '0) && (d2_tag.len != '0) && !d2_ovf_a && !d2_ovf_b;
    if (d2_tag.circ) begin
      ox_nxt = '0;
      oy_nxt = '0;
      if (circ_ok) begin
        ox_nxt = d2_tag.neg_x ? OW'(-{1'b0, d2_q_a}) : OW'({1'b0, d2_q_a});
        oy_nxt = d2_tag.neg_y ? OW'(-{1'b0, d2_q_b}) : OW'({1'b0, d2_q_b});
      end
    end else begin
      ox_nxt = d2_tag.rx;
      oy_nxt = d2_tag.ry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
  end

  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;

endmodule

>>> bench/tb.sv
// Self-checking bench for joystick_dead_zone_unit: directed and random stick samples
// through none, axis and circular modes, checked against an in-bench predictor.
// Depends on jdz_pkg and the unit RTL.
module tb;

  localparam int LATENCY = 53;
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [jdz_pkg::SAMPLE_BITS-1:0] in_raw_x = '0, in_raw_y = '0;
  logic out_valid;
  logic signed [jdz_pkg::OUT_W-1:0] out_x, out_y;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [jdz_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  typedef struct packed {
    logic signed [jdz_pkg::OUT_W-1:0] x;
    logic signed [jdz_pkg::OUT_W-1:0] y;
  } stick_out_t;

  stick_out_t expected_q[$];
  logic [1:0] mode_r;
  logic [jdz_pkg::SAMPLE_BITS-1:0] max_r;
  logic [jdz_pkg::DZ_W-1:0] dz_r;
  int mismatches = 0, results_seen = 0, sent = 0;
  int send_idle_pct = 0;
  longint cycles = 0;

  joystick_dead_zone_unit uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint clamp_unit(longint v);
    longint one = longint'(1) << jdz_pkg::FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint floor_root(longint n);
    longint r = 0;
    while ((r + 1) * (r + 1) <= n) r = r + ((((r + 1) * 2) * ((r + 1) * 2) <= n) ? r + 1 : 1);
    while (r * r > n) r--;
    return r;
  endfunction

  function automatic longint shrink(longint v, longint dz, longint span);
    if (v < -dz) v = v + dz;
    else if (v > dz) v = v - dz;
    else return 0;
    return clamp_unit((v * (longint'(1) << jdz_pkg::FRAC_BITS)) / span);
  endfunction

  function automatic stick_out_t condition(logic signed [jdz_pkg::SAMPLE_BITS-1:0] sx,
                                           logic signed [jdz_pkg::SAMPLE_BITS-1:0] sy);
    longint x = sx, y = sy, dz, span, len, w;
    stick_out_t r;
    r = '0;
    dz = (mode_r == jdz_pkg::MODE_AXIS || mode_r == jdz_pkg::MODE_CIRC) ?
         longint'(dz_r) : 0;
    span = longint'(max_r) - dz;
    if (span > 0) begin
      if (mode_r == jdz_pkg::MODE_CIRC) begin
        len = floor_root(x * x + y * y);
        w = shrink(len, dz, span);
        if (w > 0 && len > 0) begin
          r.x = jdz_pkg::OUT_W'(clamp_unit((x * w) / len));
          r.y = jdz_pkg::OUT_W'(clamp_unit((y * w) / len));
        end
      end else begin
        r.x = jdz_pkg::OUT_W'(shrink(x, dz, span));
        r.y = jdz_pkg::OUT_W'(shrink(y, dz, span));
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    stick_out_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat x=%0d y=%0d", out_x, out_y);
      end else begin
        e = expected_q.pop_front();
        if (e.x !== out_x || e.y !== out_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     e.x, e.y, out_x, out_y);
        end
      end
    end
  end

  task automatic send_sample(logic signed [jdz_pkg::SAMPLE_BITS-1:0] sx,
                             logic signed [jdz_pkg::SAMPLE_BITS-1:0] sy);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_raw_x <= sx;
    in_raw_y <= sy;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(condition(sx, sy));
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= jdz_pkg::ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      jdz_pkg::REG_MODE: mode_r = val[1:0];
      jdz_pkg::REG_MAX:  max_r = val[jdz_pkg::SAMPLE_BITS-1:0];
      default:           dz_r = val[jdz_pkg::DZ_W-1:0];
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic setup(logic [1:0] m, logic [31:0] mx, logic [31:0] dz);
    drain();
    write_reg(jdz_pkg::REG_MODE, 32'(m));
    write_reg(jdz_pkg::REG_MAX, mx);
    write_reg(jdz_pkg::REG_DZ, dz);
  endtask

  task automatic test_directed();
    logic signed [jdz_pkg::SAMPLE_BITS-1:0] v[6] = '{-32768, 32767, 0, -1, 7849, -7850};
    // reset settings first, then each mode incl. unused mode code three
    foreach (v[i]) send_sample(v[i], v[5 - i]);
    for (int m = 0; m < 4; m++) begin
      setup(m[1:0], 32767, 7849);
      send_sample(-32768, -32768);
      send_sample(32767, 0);
      send_sample(0, 0);
      send_sample(7849, -7849);
      send_sample(3000, 4000);
    end
    // span zero, incl. max zero; then max 32768 in none mode
    setup(jdz_pkg::MODE_CIRC, 100, 100);
    send_sample(32767, 5);
    setup(jdz_pkg::MODE_AXIS, 0, 0);
    send_sample(-32768, 1);
    setup(jdz_pkg::MODE_NONE, 32768, 32767);
    send_sample(-32768, 32767);
    send_sample(-16384, 1);
  endtask

  task automatic random_phase(int n, int idle);
    send_idle_pct = idle;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_sample(jdz_pkg::SAMPLE_BITS'($urandom_range(600) - 300),
                    jdz_pkg::SAMPLE_BITS'($urandom));
      else
        send_sample(jdz_pkg::SAMPLE_BITS'($urandom), jdz_pkg::SAMPLE_BITS'($urandom));
    end
    send_idle_pct = 0;
  endtask

  task automatic test_random();
    int idles[4] = '{0, 59, 0, 36};
    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: setup(2'($urandom_range(3)), $urandom_range(1, 65535), $urandom_range(32767));
        1: setup(jdz_pkg::MODE_CIRC, $urandom_range(1000, 32768), $urandom_range(0, 9000));
        2: setup(jdz_pkg::MODE_AXIS, 32768, 0);
        default: setup(2'($urandom_range(3)), $urandom_range(65535), $urandom);
      endcase
      random_phase(170, idles[p % 4]);
      if (p == 5) drain();  // sender holds off until every result is back
    end
  endtask

  initial begin
    mode_r = jdz_pkg::RST_MODE;
    max_r = jdz_pkg::RST_MAX;
    dz_r = jdz_pkg::RST_DZ;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    drain();
    $display("covered %0d samples over none, axis, circular and mode-three settings;",
             sent);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
